// ===== hw/rtl/lbm_pkg.sv =====
// ----------------------------------------------------------------------------
// lbm_pkg
// Shared types, codes and helper functions for the LED bar meter scan limiter.
// ----------------------------------------------------------------------------
package lbm_pkg;

	localparam int MODULES_DEF = 8;
	localparam int BAR_LEDS    = 16;
	localparam int PHASE_W     = 4;
	localparam int LEVEL_W     = 5;
	localparam int LIMIT_W     = 5;
	localparam int SLAVE_W     = 3;
	localparam int ID_W        = 3;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;

	localparam logic [MODE_W-1:0] MODE_LEVEL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SCAN    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLAVES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIT       = 2'd1;

	typedef struct packed {
		logic            last;
		logic [ID_W-1:0] index;
	} lbm_s1_t;

	function automatic logic [BAR_LEDS-1:0] thermo_code(input logic [LEVEL_W-1:0] level);
		logic [BAR_LEDS-1:0] p;
		p = '0;
		for (int i = 0; i < BAR_LEDS; i++) begin
			if (LEVEL_W'(i) < level) p[i] = 1'b1;
		end
		return p;
	endfunction

	function automatic logic [BAR_LEDS-1:0] window_mask(
		input logic [BAR_LEDS-1:0] pat,
		input logic [PHASE_W-1:0]  phase,
		input logic [LIMIT_W-1:0]  max_lit
	);
		logic [BAR_LEDS-1:0] word;
		logic [PHASE_W-1:0]  pos;
		word = '0;
		for (int b = 0; b < BAR_LEDS; b++) begin
			pos = PHASE_W'(b) - phase;
			if (pat[b] && ({1'b0, pos} < max_lit)) word[b] = 1'b1;
		end
		return word;
	endfunction

endpackage

// ===== hw/rtl/led_bar_meter_scan_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// led_bar_meter_scan_limiter_unit
// Per-module LED bar pattern store with a scan that emits masked words,
// highest module first, through a rotating window of allowed LEDs.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / data                         | tuser / tlast
//  s_axis   | in        | [2:0] module_id [7:3] level [23:8] pattern | tuser mode
//  m_axis   | out       | [15:0] led_word [18:16] module_index | tlast last
//  cfg      | in        | cfg_index, cfg_data (register write)  | -
//
//  Level and pattern writes complete when accepted. After a scan tick is
//  accepted the input is held off while the pattern memory is read, one read
//  per module, so the next transaction is taken only once the last module has
//  been read; the single memory read port sets the pace. Each word passes the
//  registered memory read and then the output register. A stalled output stops
//  the reads and holds the pipeline without loss. Reset clears the store (valid
//  bits), the phase and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module led_bar_meter_scan_limiter_unit #(
	parameter int MODULES = lbm_pkg::MODULES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [23:0]                     s_axis_tdata,  // module_id, level, pattern
	input  logic [lbm_pkg::MODE_W-1:0]      s_axis_tuser,  // mode
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [23:0]                     m_axis_tdata,  // led_word, module_index, zero fill
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lbm_pkg::*;

	localparam int ADDR_W = (MODULES > 1) ? $clog2(MODULES) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                state_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [SLAVE_W-1:0]  active_slaves_q;
	logic [LIMIT_W-1:0]  max_lit_q;
	logic                s1_valid_q;
	lbm_s1_t             s1_ctl_q;

	logic [ID_W-1:0]     in_id;
	logic [LEVEL_W-1:0]  in_level;
	logic [BAR_LEDS-1:0] in_pattern;
	logic                in_acc;
	logic                id_ok;
	logic                wr_en;
	logic [BAR_LEDS-1:0] wr_data;
	logic                rd_en;
	logic [BAR_LEDS-1:0] rd_data;
	logic                out_free;
	logic                s1_move;
	logic [BAR_LEDS-1:0] out_word;
	logic [ID_W-1:0]     out_index;

	assign in_id      = s_axis_tdata[2:0];
	assign in_level   = s_axis_tdata[7:3];
	assign in_pattern = s_axis_tdata[23:8];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	assign id_ok = (in_id <= active_slaves_q) && (int'(in_id) < MODULES);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = in_pattern;
		unique case (s_axis_tuser)
			MODE_LEVEL: begin
				wr_en   = in_acc && id_ok;
				wr_data = thermo_code(in_level);
			end
			MODE_PATTERN: begin
				wr_en = in_acc && id_ok;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign s1_move = s1_valid_q && out_free;
	assign rd_en   = (state_q == ST_SCAN) && (!s1_valid_q || s1_move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slaves_q <= 3'd7;
			max_lit_q       <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ACTIVE_SLAVES: active_slaves_q <= cfg_data[SLAVE_W-1:0];
				CFG_MAX_LIT:       max_lit_q       <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			s1_valid_q <= 1'b0;
			phase_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == MODE_SCAN)) begin
						state_q <= ST_SCAN;
						cnt_q   <= ADDR_W'(MODULES - 1);
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == '0) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move && s1_ctl_q.last) phase_q <= phase_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			s1_ctl_q.last  <= (cnt_q == '0);
			s1_ctl_q.index <= ID_W'(cnt_q);
		end
	end

	lbm_pattern_mem #(
		.MODULES (MODULES),
		.ADDR_W  (ADDR_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (ADDR_W'(in_id)),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (cnt_q),
		.rd_data (rd_data)
	);

	lbm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (s1_move),
		.pat       (rd_data),
		.ctl       (s1_ctl_q),
		.phase     (phase_q),
		.max_lit   (max_lit_q),
		.take      (m_axis_tready),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_word  (out_word),
		.out_index (out_index),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, out_index, out_word};

`ifndef SYNTH
	a_last_is_module0: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[18:16] == 3'd0)
		else $error("last word not from module 0");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_axis_tuser == MODE_SCAN) |=>
		(state_q == ST_SCAN) && (cnt_q == ADDR_W'(MODULES - 1)))
		else $error("scan did not start at highest module");

	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(phase_q) |-> $past(s1_move && s1_ctl_q.last))
		else $error("phase moved outside end of scan");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_ctl_q))
		else $error("stalled read stage changed");
`endif

endmodule

// ===== hw/rtl/lbm_pattern_mem.sv =====
// ----------------------------------------------------------------------------
// lbm_pattern_mem
// Bar pattern store: one write port, one registered read port, per-entry
// valid bits so that entries never written read as zero.
// ----------------------------------------------------------------------------
module lbm_pattern_mem #(
	parameter int MODULES = lbm_pkg::MODULES_DEF,
	parameter int ADDR_W  = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [lbm_pkg::BAR_LEDS-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [ADDR_W-1:0]             rd_addr,
	output logic [lbm_pkg::BAR_LEDS-1:0]  rd_data
);
	import lbm_pkg::*;

	logic [BAR_LEDS-1:0] mem [MODULES];
	logic [MODULES-1:0]  valid_q;
	logic [BAR_LEDS-1:0] rd_data_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/lbm_out_stage.sv =====
// ----------------------------------------------------------------------------
// lbm_out_stage
// Applies the rotating window mask to a read pattern and holds the result
// in the output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module lbm_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [lbm_pkg::BAR_LEDS-1:0]  pat,
	input  lbm_pkg::lbm_s1_t              ctl,
	input  logic [lbm_pkg::PHASE_W-1:0]   phase,
	input  logic [lbm_pkg::LIMIT_W-1:0]   max_lit,
	input  logic                          take,
	output logic                          free,
	output logic                          out_valid,
	output logic [lbm_pkg::BAR_LEDS-1:0]  out_word,
	output logic [lbm_pkg::ID_W-1:0]      out_index,
	output logic                          out_last
);
	import lbm_pkg::*;

	logic                out_valid_q;
	logic [BAR_LEDS-1:0] out_word_q;
	logic [ID_W-1:0]     out_index_q;
	logic                out_last_q;

	assign free = !out_valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_word_q  <= window_mask(pat, phase, max_lit);
			out_index_q <= ctl.index;
			out_last_q  <= ctl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

endmodule
